/* sv/les_pkg.sv */
// ----------------------------------------------------------------------------
// les_pkg
// shared types and constants for the linear equation solver
// ----------------------------------------------------------------------------
package les_pkg;

    localparam int SYMBOL_W = 8;
    localparam int STATUS_W = 2;
    localparam int SOL_W    = 32;

    localparam logic [STATUS_W-1:0] STATUS_UNIQUE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INFINITE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd2;

    localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYMBOL_W-1:0] CH_X     = 8'h78;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } les_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [SOL_W-1:0] solution;
    } les_result_t;

    typedef struct packed {
        logic fold;
        logic flush;
        logic clear;
    } les_ctrl_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FLUSH = 6'b000010,
        ST_SOLVE = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } les_state_t;

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_ITER = 3'b010,
        DV_FIX  = 3'b100
    } les_div_state_t;

endpackage

/* sv/les_parser.sv */
// ----------------------------------------------------------------------------
// les_parser
// folds equation characters into coefficient and constant accumulators
// ----------------------------------------------------------------------------
module les_parser #(
    parameter int WORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  les_pkg::les_ctrl_t    ctrl,
    input  les_pkg::les_req_t     req,
    output logic [WORD_WIDTH-1:0] left_coef,
    output logic [WORD_WIDTH-1:0] left_const,
    output logic [WORD_WIDTH-1:0] right_coef,
    output logic [WORD_WIDTH-1:0] right_const
);
    import les_pkg::*;

    logic [WORD_WIDTH-1:0] lc_reg, lc_next;
    logic [WORD_WIDTH-1:0] lk_reg, lk_next;
    logic [WORD_WIDTH-1:0] rc_reg, rc_next;
    logic [WORD_WIDTH-1:0] rk_reg, rk_next;
    logic [WORD_WIDTH-1:0] pend_reg, pend_next;
    logic                  side_reg, side_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;

    logic                  is_digit;
    logic                  is_x;
    logic                  is_sign;
    logic [WORD_WIDTH-1:0] pend_x;
    logic [WORD_WIDTH-1:0] term_mag;
    logic [WORD_WIDTH-1:0] term;
    logic [WORD_WIDTH-1:0] flush_term;
    logic [WORD_WIDTH-1:0] pend_ten;

    assign is_digit   = (req.symbol >= CH_ZERO) && (req.symbol <= CH_NINE);
    assign is_x       = (req.symbol == CH_X);
    assign is_sign    = (req.symbol == CH_PLUS) || (req.symbol == CH_MINUS);
    assign pend_x     = (pend_reg == '0) ? (zero_reg ? '0 : WORD_WIDTH'(1)) : pend_reg;
    assign term_mag   = is_x ? pend_x : pend_reg;
    assign term       = neg_reg ? (WORD_WIDTH'(0) - term_mag) : term_mag;
    assign flush_term = neg_reg ? (WORD_WIDTH'(0) - pend_reg) : pend_reg;
    assign pend_ten   = (pend_reg << 3) + (pend_reg << 1) + WORD_WIDTH'(req.symbol[3:0]);

    always_comb
    begin
        lc_next   = lc_reg;
        lk_next   = lk_reg;
        rc_next   = rc_reg;
        rk_next   = rk_reg;
        pend_next = pend_reg;
        side_next = side_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (ctrl.clear)
        begin
            lc_next   = '0;
            lk_next   = '0;
            rc_next   = '0;
            rk_next   = '0;
            pend_next = '0;
            side_next = 1'b0;
            neg_next  = 1'b0;
            zero_next = 1'b0;
        end
        else if (ctrl.flush)
        begin
            rk_next = rk_reg + flush_term;
        end
        else if (ctrl.fold)
        begin
            if (is_digit)
            begin
                pend_next = pend_ten;
            end
            else if (is_x)
            begin
                if (side_reg)
                begin
                    rc_next = rc_reg + term;
                end
                else
                begin
                    lc_next = lc_reg + term;
                end
                pend_next = '0;
                neg_next  = 1'b0;
            end
            else if (is_sign)
            begin
                if (side_reg)
                begin
                    rk_next = rk_reg + term;
                end
                else
                begin
                    lk_next = lk_reg + term;
                end
                pend_next = '0;
                neg_next  = (req.symbol == CH_MINUS);
            end
            else
            begin
                // anything else acts as the equals sign
                lk_next   = lk_reg + term;
                pend_next = '0;
                neg_next  = 1'b0;
                side_next = 1'b1;
            end
            zero_next = (req.symbol == CH_ZERO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg   <= '0;
            lk_reg   <= '0;
            rc_reg   <= '0;
            rk_reg   <= '0;
            pend_reg <= '0;
            side_reg <= 1'b0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            lc_reg   <= lc_next;
            lk_reg   <= lk_next;
            rc_reg   <= rc_next;
            rk_reg   <= rk_next;
            pend_reg <= pend_next;
            side_reg <= side_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
        end
    end

    assign left_coef   = lc_reg;
    assign left_const  = lk_reg;
    assign right_coef  = rc_reg;
    assign right_const = rk_reg;

endmodule

/* sv/les_divider.sv */
// ----------------------------------------------------------------------------
// les_divider
// signed truncating divider, one restoring subtract step per cycle
// ----------------------------------------------------------------------------
module les_divider #(
    parameter int WORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] dividend,
    input  logic [WORD_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] quotient
);
    import les_pkg::*;

    localparam int CNT_W = $clog2(WORD_WIDTH);

    les_div_state_t        state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic [WORD_WIDTH-1:0] qd_reg, qd_next;
    logic [WORD_WIDTH-1:0] den_reg, den_next;
    logic                  negq_reg, negq_next;
    logic [WORD_WIDTH:0]   trial;

    assign trial = {rem_reg, qd_reg[WORD_WIDTH-1]} - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        qd_next    = qd_reg;
        den_next   = den_reg;
        negq_next  = negq_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    rem_next   = '0;
                    qd_next    = dividend[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - dividend) : dividend;
                    den_next   = divisor[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - divisor) : divisor;
                    negq_next  = dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
                    cnt_next   = CNT_W'(WORD_WIDTH - 1);
                    state_next = DV_ITER;
                end
            end
            DV_ITER:
            begin
                if (!trial[WORD_WIDTH])
                begin
                    rem_next = trial[WORD_WIDTH-1:0];
                    qd_next  = {qd_reg[WORD_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[WORD_WIDTH-2:0], qd_reg[WORD_WIDTH-1]};
                    qd_next  = {qd_reg[WORD_WIDTH-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = DV_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            DV_FIX:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        qd_reg   <= qd_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
    end

    assign done     = (state_reg == DV_FIX);
    assign quotient = negq_reg ? (WORD_WIDTH'(0) - qd_reg) : qd_reg;

endmodule

/* sv/linear_equation_solver.sv */
// ----------------------------------------------------------------------------
// linear_equation_solver
// parses a one-variable linear equation character by character and solves it
//
// requests arrive on char_valid/char_stall/char_req, one ASCII character each,
// with last marking the final character; results leave on
// result_valid/result_stall/result as a status and a 32-bit solution.
// ordinary characters are taken one per cycle. after the last character the
// block stalls requests while it flushes, compares the coefficients and, if
// they differ, runs the divider, one restoring step per cycle. the result
// goes to emit straight from the compare when the coefficients match and
// through load and divide otherwise; a result side stall holds emit, and the
// next equation, only while an earlier result is still waiting to be taken.
// the result sits in an output register until taken; a stalled result holds
// and blocks only the next result, not the parsing of the next equation.
// reset clears all accumulators and returns the block to idle, ready for a
// fresh equation; the accumulators clear the same way in each solve state.
// ----------------------------------------------------------------------------
module linear_equation_solver #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  les_pkg::les_req_t    char_req,
    output logic                 result_valid,
    input  logic                 result_stall,
    output les_pkg::les_result_t result
);
    import les_pkg::*;

    les_state_t            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    les_result_t           result_reg;
    logic [WORD_WIDTH-1:0] num_reg;
    logic [WORD_WIDTH-1:0] den_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SOL_W-1:0]      sol_reg;

    les_ctrl_t             ctrl;
    logic                  accept;
    logic                  out_free;
    logic                  emit;
    logic                  coef_equal;
    logic                  coef_greater;
    logic [WORD_WIDTH-1:0] left_coef;
    logic [WORD_WIDTH-1:0] left_const;
    logic [WORD_WIDTH-1:0] right_coef;
    logic [WORD_WIDTH-1:0] right_const;
    logic                  div_done;
    logic [WORD_WIDTH-1:0] div_quotient;

    assign char_stall   = (state_reg != ST_IDLE);
    assign accept       = char_valid && !char_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign emit         = (state_reg == ST_EMIT) && out_free;
    assign coef_equal   = (left_coef == right_coef);
    assign coef_greater = ($signed(left_coef) > $signed(right_coef));

    always_comb
    begin
        ctrl.fold  = accept;
        ctrl.flush = (state_reg == ST_FLUSH);
        ctrl.clear = (state_reg == ST_SOLVE);
    end

    les_parser #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .req         (char_req),
        .left_coef   (left_coef),
        .left_const  (left_const),
        .right_coef  (right_coef),
        .right_const (right_const)
    );

    les_divider #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && char_req.last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_SOLVE;
            end
            ST_SOLVE:
            begin
                state_next = coef_equal ? ST_EMIT : ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SOLVE)
        begin
            num_reg <= coef_greater ? (right_const - left_const) : (left_const - right_const);
            den_reg <= coef_greater ? (left_coef - right_coef) : (right_coef - left_coef);
            sol_reg <= '0;
            if (!coef_equal)
            begin
                status_reg <= STATUS_UNIQUE;
            end
            else if (left_const == right_const)
            begin
                status_reg <= STATUS_INFINITE;
            end
            else
            begin
                status_reg <= STATUS_NONE;
            end
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            sol_reg <= SOL_W'(div_quotient);
        end
        if (emit)
        begin
            result_reg.status   <= status_reg;
            result_reg.solution <= $signed(sol_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // no request is taken in the cycle after the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && char_req.last) |=> char_stall)
        else $error("request taken during solve");

    // divider completes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide phase");

    // status is always one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_UNIQUE ||
                          result.status == STATUS_INFINITE ||
                          result.status == STATUS_NONE))
        else $error("bad status code");

    // without a unique solution the solution field is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != STATUS_UNIQUE)) |-> (result.solution == '0))
        else $error("nonzero solution without unique status");
`endif

endmodule

/* bench/les_checker.sv */
// ----------------------------------------------------------------------------
// les_checker
// watches both channels of the linear equation solver and checks every result
//
// each accepted request is folded into a private copy of the parse state:
// pending number and sign, per-side x coefficient and constant. the request
// marked last closes the equation. the checker then works out the expected
// status and the solution, truncated toward zero, and queues them. each
// accepted result is compared field by field with the oldest queued
// solution. the mismatch count and the number of solutions still due are
// handed to the top.
// ----------------------------------------------------------------------------
module les_checker
    import les_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_stall,
    input  les_req_t    char_req,
    input  logic        result_valid,
    input  logic        result_stall,
    input  les_result_t result,
    output int          failures,
    output int          outstanding
);

    logic [31:0] left_coef;
    logic [31:0] left_const;
    logic [31:0] right_coef;
    logic [31:0] right_const;
    logic        on_right;
    logic [31:0] pend;
    logic        pend_neg;
    logic        prev_zero;

    les_result_t solutions_due[$];
    int          fail_count;

    function automatic void clear_equation();
        left_coef   = '0;
        left_const  = '0;
        right_coef  = '0;
        right_const = '0;
        on_right    = 1'b0;
        pend        = '0;
        pend_neg    = 1'b0;
        prev_zero   = 1'b0;
    endfunction

    function automatic logic [31:0] signed_pend();
        return pend_neg ? -pend : pend;
    endfunction

    // quotient truncated toward zero, most negative / -1 wraps
    function automatic logic [31:0] trunc_div(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] mag_num;
        logic [31:0] mag_den;
        logic [31:0] quo;
        mag_num = num[31] ? -num : num;
        mag_den = den[31] ? -den : den;
        quo     = mag_num / mag_den;
        return (num[31] != den[31]) ? -quo : quo;
    endfunction

    function automatic void fold_symbol(input logic [7:0] sym, input logic fin);
        les_result_t sol;
        if (sym >= CH_ZERO && sym <= CH_NINE) begin
            pend = pend * 32'd10 + 32'(sym - CH_ZERO);
        end
        else if (sym == CH_X) begin
            if (pend == '0 && !prev_zero)
                pend = 32'd1;
            if (on_right)
                right_coef = right_coef + signed_pend();
            else
                left_coef = left_coef + signed_pend();
            pend     = '0;
            pend_neg = 1'b0;
        end
        else if (sym == CH_PLUS || sym == CH_MINUS) begin
            if (on_right)
                right_const = right_const + signed_pend();
            else
                left_const = left_const + signed_pend();
            pend     = '0;
            pend_neg = (sym == CH_MINUS);
        end
        else begin
            // anything else behaves as the equals sign
            left_const = left_const + signed_pend();
            pend       = '0;
            pend_neg   = 1'b0;
            on_right   = 1'b1;
        end
        prev_zero = (sym == CH_ZERO);

        if (fin) begin
            right_const = right_const + signed_pend();
            if (left_coef == right_coef) begin
                sol.status   = (left_const == right_const) ? STATUS_INFINITE : STATUS_NONE;
                sol.solution = '0;
            end
            else begin
                sol.status = STATUS_UNIQUE;
                if ($signed(left_coef) > $signed(right_coef))
                    sol.solution = trunc_div(right_const - left_const, left_coef - right_coef);
                else
                    sol.solution = trunc_div(left_const - right_const, right_coef - left_coef);
            end
            solutions_due.push_back(sol);
            clear_equation();
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        les_result_t want;
        if (!rst_n) begin
            clear_equation();
            solutions_due.delete();
            fail_count = 0;
            outstanding <= 0;
            failures    <= 0;
        end
        else begin
            if (char_valid && !char_stall)
                fold_symbol(char_req.symbol, char_req.last);
            if (result_valid && !result_stall) begin
                if (solutions_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: unexpected result status %0d solution %0d",
                                 result.status, result.solution);
                end
                else begin
                    want = solutions_due.pop_front();
                    if (want.status !== result.status || want.solution !== result.solution) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected status %0d solution %0d, ",
                                      "got status %0d solution %0d"},
                                     want.status, want.solution,
                                     result.status, result.solution);
                    end
                end
            end
            outstanding <= solutions_due.size();
            failures    <= fail_count;
        end
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the linear equation solver
//
// sends a few hand-written equations covering zero coefficients, no solution,
// wrapped constants with the quotient overflow, and stray bytes acting as the
// equals sign, then random equations: mostly well-formed with random terms,
// some corrupted or pure noise. both sides idle at random, the result side
// once holds off long enough to back the block up, and the sender
// periodically waits for all results. checking is done by les_checker.
// ----------------------------------------------------------------------------
module tb;

    import les_pkg::*;

    localparam logic [7:0] CH_EQUALS   = 8'h3d;
    localparam int         ITEM_TARGET = 1550;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         LONG_HOLD   = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        char_valid;
    logic        char_stall;
    les_req_t    char_req;
    logic        result_valid;
    logic        result_stall;
    les_result_t result;

    int          failures;
    int          outstanding;
    int          chars_sent = 0;
    int          eqn_count = 0;
    int          taken = 0;
    int          idle_cycles = 0;
    logic [7:0]  eqn[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    linear_equation_solver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_req     (char_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    les_checker solve_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_req     (char_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    task automatic send_char(input logic [7:0] sym, input logic fin);
        int gap;
        gap = ((chars_sent % 300) >= 250) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_req.symbol <= sym;
        char_req.last   <= fin;
        char_valid      <= 1'b1;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_eqn();
        for (int i = 0; i < eqn.size(); i++)
            send_char(eqn[i], i == eqn.size() - 1);
        eqn.delete();
        eqn_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            eqn.push_back(s[i]);
    endtask

    task automatic wait_for_results();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic void add_term(input bit lead);
        int shape;
        int digits;
        shape = $urandom_range(0, 9);
        if (!lead || shape < 3)
            eqn.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        // leading zero, and a bare zero coefficient when no digits follow
        if (shape == 8)
            eqn.push_back(CH_ZERO);
        digits = (shape == 9) ? $urandom_range(8, 12) : $urandom_range(0, 2);
        for (int i = 0; i < digits; i++)
            eqn.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if (digits == 0 || $urandom_range(0, 1))
            eqn.push_back(CH_X);
    endfunction

    function automatic void add_side();
        int terms;
        terms = $urandom_range(1, 3);
        for (int t = 0; t < terms; t++)
            add_term(t == 0);
    endfunction

    function automatic void build_random();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) eqn.push_back(8'($urandom_range(0, 255)));
        end
        else begin
            add_side();
            eqn.push_back((kind == 1) ? 8'($urandom_range(0, 255)) : CH_EQUALS);
            add_side();
            if (kind == 2)
                eqn[$urandom_range(0, eqn.size() - 1)] = 8'($urandom_range(0, 255));
            if (kind == 3) begin
                eqn.push_back(CH_EQUALS);
                add_side();
            end
        end
    endfunction

    // result side: random stalls, one long hold-off, some stretches without stalls
    initial begin
        int hold;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = ((taken % 40) >= 34) ? 0 : $urandom_range(0, 6);
            if (taken == 25)
                hold = LONG_HOLD;
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!(result_valid && !result_stall))
                @(posedge clk);
            taken++;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** linear_equation_solver: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_req   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero coefficient, infinite solutions
        push_text("0x=0");
        send_eqn();
        // equal coefficients, no solution
        push_text("x=x1");
        send_eqn();
        // stray byte as equals, wrapped constant
        push_text("-x");
        eqn.push_back(8'hff);
        push_text("2147483648");
        send_eqn();
        // most negative divided by minus one
        push_text("2147483647x=2147483648x+2147483648");
        send_eqn();
        // repeated equals from null bytes
        eqn.push_back(8'h00);
        eqn.push_back(8'h00);
        eqn.push_back(CH_X);
        send_eqn();

        while (chars_sent < ITEM_TARGET) begin
            build_random();
            send_eqn();
            if (eqn_count % 45 == 20)
                wait_for_results();
        end

        wait_for_results();
        repeat (80) @(posedge clk);
        if (failures == 0)
            $display("** linear_equation_solver: PASSED **");
        else
            $display("** linear_equation_solver: FAILED **");
        $finish;
    end

endmodule
